// ----- hdl/gagg_pkg.sv -----
// Shared types, constants and codes of the growth aggregation step block.
package gagg_pkg;

  // Fixed field widths.
  localparam int SIZE_BITS  = 48;
  localparam int FRAC_W     = 16;
  localparam int GROWTH_W   = 16;
  localparam int COUNT_W    = 11;
  localparam int STEP_W     = 11;
  localparam int SNAP_W     = 10;
  localparam int PICK_W     = 10;
  localparam int BSEL_W     = 6;
  localparam int BINCNT_W   = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Default sizing of the storage.
  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int NUM_BINS_DEF      = 64;

  // A unit particle, 1.0 in Q32.16.
  localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1) << FRAC_W;

  // Register reset values.
  localparam logic [COUNT_W-1:0]   INIT_COUNT_RST = 11'd1024;
  localparam logic [GROWTH_W-1:0]  GROWTH_RST     = 16'd0;
  localparam logic [SNAP_W-1:0]    SNAP_STEP_RST  = 10'd1;
  localparam logic [SIZE_BITS-1:0] BIN_WIDTH_RST  = 48'd65536;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_MERGE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } gagg_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_COUNT = 2'd0,
    CFG_GROWTH_RATE   = 2'd1,
    CFG_SNAPSHOT_STEP = 2'd2,
    CFG_BIN_WIDTH     = 2'd3
  } gagg_cfg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PICK_W-1:0] first_pick;
    logic [PICK_W-1:0] second_pick;
    logic [BSEL_W-1:0] bin_select;
  } gagg_req_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] merged_size;
    logic [COUNT_W-1:0]   particles_left;
    logic                 snapshot_done;
    logic                 bad_pick;
    logic                 run_finished;
    logic [BINCNT_W-1:0]  bin_count;
  } gagg_rsp_t;

  typedef struct packed {
    logic done;
    logic hit;
  } gagg_div_status_t;

endpackage

// ----- hdl/gagg_bin_div.sv -----
// Iterative bin locator: bin = ceil(size / width) - 1, one quotient bit per cycle.
module gagg_bin_div #(
  parameter int NUM_BINS = gagg_pkg::NUM_BINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [gagg_pkg::SIZE_BITS-1:0]   size,
  input  logic [gagg_pkg::SIZE_BITS-1:0]   width,
  output gagg_pkg::gagg_div_status_t       status,
  output logic [$clog2(NUM_BINS)-1:0]      bin
);
  import gagg_pkg::*;

  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int DV_W       = SIZE_BITS + BIN_W - 1;
  localparam int OV_W       = SIZE_BITS + BIN_W;
  localparam int STEP_CNT_W = $clog2(BIN_W + 1);

  logic                  busy;
  logic                  done;
  logic                  hit;
  logic [SIZE_BITS-1:0]  rem;
  logic [DV_W-1:0]       dvs;
  logic [STEP_CNT_W-1:0] cnt;
  logic [SIZE_BITS-1:0]  num;
  logic [SIZE_BITS-1:0]  divisor;
  logic                  overflow;
  logic                  take;
  logic [BIN_W-1:0]      q_next;

  // ceil(s/w) - 1 equals floor((s-1)/w) for nonzero s. A zero width counts as one.
  always_comb begin
    divisor  = (width == '0) ? SIZE_BITS'(1) : width;
    num      = size - SIZE_BITS'(1);
    overflow = OV_W'(num) >= {divisor, {BIN_W{1'b0}}};
    take     = DV_W'(rem) >= dvs;
    q_next   = (bin << 1) | BIN_W'(take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (size == '0 || overflow) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= DV_W'(divisor) << (BIN_W - 1);
      bin <= '0;
      cnt <= STEP_CNT_W'(BIN_W - 1);
      hit <= 1'b0;
    end else if (busy) begin
      if (take) begin
        rem <= rem - dvs[SIZE_BITS-1:0];
      end
      dvs <= dvs >> 1;
      bin <= q_next;
      cnt <= cnt - STEP_CNT_W'(1);
      if (cnt == '0) begin
        hit <= 32'(q_next) < NUM_BINS;
      end
    end
  end

  assign status.done = done;
  assign status.hit  = hit;

endmodule

// ----- hdl/growth_aggregation_step.sv -----
// Top level of the growth aggregation step: particle size table, merge datapath, histogram.
//
//   Channel   Signals                              Direction  Handshake
//   request   req_valid, req_stall, req            in         accepted: valid high, stall low
//   result    rsp_valid, rsp_stall, rsp            out        taken: valid high, stall low
//   config    cfg_valid, cfg_ready, cfg_index,     in         written: valid and ready high
//             cfg_data
//
// One item is worked on at a time; the next item is taken as soon as the state machine is
// back in idle, even while the previous result still waits in the output register.
// A merge makes three reads of the size memory, one add, one multiply and two write-backs,
// all through its single read and single write port. A rejected merge and the unused
// mode go straight from idle to done. A snapshot merge then walks each particle left
// through the bit-serial bin locator and the read-modify-write of the histogram memory;
// an empty size or one past the last bin skips the histogram write.
// A run start writes min(initial_count, MAX_PARTICLES) particles, one memory write each.
// A bin read makes one read of the histogram memory.
// After reset, the histogram memory is cleared by a sweep over all NUM_BINS bins, during
// which no item is accepted; configuration writes are taken at any time.
module growth_aggregation_step #(
  parameter int MAX_PARTICLES = gagg_pkg::MAX_PARTICLES_DEF,
  parameter int NUM_BINS      = gagg_pkg::NUM_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  gagg_pkg::gagg_req_t               req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output gagg_pkg::gagg_rsp_t               rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gagg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gagg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gagg_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PARTICLES);
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int PROD_W = SIZE_BITS + GROWTH_W;

  typedef enum logic [13:0] {
    ST_CLEAR   = 14'b00000000000001,
    ST_IDLE    = 14'b00000000000010,
    ST_FILL    = 14'b00000000000100,
    ST_MRD1    = 14'b00000000001000,
    ST_MRD2    = 14'b00000000010000,
    ST_MRD3    = 14'b00000000100000,
    ST_MWR1    = 14'b00000001000000,
    ST_MWR2    = 14'b00000010000000,
    ST_SN_RD   = 14'b00000100000000,
    ST_SN_DIV  = 14'b00001000000000,
    ST_SN_WAIT = 14'b00010000000000,
    ST_SN_HWR  = 14'b00100000000000,
    ST_HREAD   = 14'b01000000000000,
    ST_DONE    = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [COUNT_W-1:0]   initial_count;
  logic [GROWTH_W-1:0]  growth_rate;
  logic [SNAP_W-1:0]    snapshot_step;
  logic [SIZE_BITS-1:0] bin_width;

  // Run state and walk counters.
  logic [CNT_W-1:0]     live;
  logic [STEP_W-1:0]    step;
  logic [CNT_W-1:0]     walk_idx;
  logic [BIN_W-1:0]     clr_idx;

  // Merge operands and the result being assembled.
  logic [IDX_W-1:0]     fp_idx;
  logic [IDX_W-1:0]     sp_idx;
  logic [IDX_W-1:0]     last_idx;
  logic [SIZE_BITS-1:0] s1;
  logic [SIZE_BITS-1:0] sum_q;
  logic [SIZE_BITS-1:0] last_val;
  logic [PROD_W-1:0]    prod;
  logic [SIZE_BITS-1:0] merged_q;
  logic                 res_bad;
  logic                 res_snap;
  logic [BINCNT_W-1:0]  res_bcount;
  logic                 bsel_ok;

  // Size memory: one read port with registered data, one write port.
  logic [SIZE_BITS-1:0] sizes [MAX_PARTICLES];
  logic [IDX_W-1:0]     size_raddr;
  logic [SIZE_BITS-1:0] size_rdata;
  logic                 size_we;
  logic [IDX_W-1:0]     size_waddr;
  logic [SIZE_BITS-1:0] size_wdata;

  // Histogram memory, cleared by a sweep after reset.
  logic [BINCNT_W-1:0]  hist [NUM_BINS];
  logic [BIN_W-1:0]     hist_raddr;
  logic [BINCNT_W-1:0]  hist_rdata;
  logic                 hist_we;
  logic [BIN_W-1:0]     hist_waddr;
  logic [BINCNT_W-1:0]  hist_wdata;

  // Bin locator.
  gagg_div_status_t     div_status;
  logic [BIN_W-1:0]     div_bin;

  // Decode of the request in idle.
  logic                 accept;
  gagg_mode_t           mode;
  logic [CMP_W-1:0]     live_w;
  logic [CMP_W-1:0]     fp_w;
  logic [CMP_W-1:0]     sp_w;
  logic [CMP_W-1:0]     init_w;
  logic [CMP_W-1:0]     start_n;
  logic                 pick_bad;

  // Merge arithmetic and walk control.
  logic [SIZE_BITS:0]   sum_full;
  logic [SIZE_BITS-1:0] sum_sat;
  logic [SIZE_BITS:0]   total_full;
  logic [SIZE_BITS-1:0] merged_sat;
  logic [STEP_W-1:0]    step_inc;
  logic                 snap_hit;
  logic                 walk_last;
  logic                 rsp_load;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign cfg_ready = 1'b1;
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    mode     = gagg_mode_t'(req.mode);
    live_w   = CMP_W'(live);
    fp_w     = CMP_W'(req.first_pick);
    sp_w     = CMP_W'(req.second_pick);
    init_w   = CMP_W'(initial_count);
    start_n  = (init_w > CMP_W'(MAX_PARTICLES)) ? CMP_W'(MAX_PARTICLES) : init_w;
    // A merge needs two live particles, two different picks, both inside the live range.
    pick_bad = (live_w < CMP_W'(2)) || (req.first_pick == req.second_pick) ||
               (fp_w >= live_w) || (sp_w >= live_w);

    // The sum and the grown total both saturate at the largest size.
    sum_full   = {1'b0, s1} + {1'b0, size_rdata};
    sum_sat    = sum_full[SIZE_BITS] ? '1 : sum_full[SIZE_BITS-1:0];
    total_full = {1'b0, sum_q} + {1'b0, prod[PROD_W-1:FRAC_W]};
    merged_sat = total_full[SIZE_BITS] ? '1 : total_full[SIZE_BITS-1:0];

    step_inc  = step + STEP_W'(1);
    snap_hit  = (step_inc == STEP_W'(snapshot_step));
    walk_last = (walk_idx == live - CNT_W'(1));
  end

  // Memory port steering.
  always_comb begin
    size_raddr = sp_idx;
    size_we    = 1'b0;
    size_waddr = fp_idx;
    size_wdata = merged_sat;
    hist_raddr = div_bin;
    hist_we    = 1'b0;
    hist_waddr = div_bin;
    hist_wdata = (hist_rdata == '1) ? hist_rdata : hist_rdata + BINCNT_W'(1);
    unique case (state)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_idx;
        hist_wdata = '0;
      end
      ST_IDLE: begin
        size_raddr = IDX_W'(req.first_pick);
        hist_raddr = BIN_W'(req.bin_select);
      end
      ST_FILL: begin
        size_we    = 1'b1;
        size_waddr = walk_idx[IDX_W-1:0];
        size_wdata = SIZE_ONE;
      end
      ST_MRD1: size_raddr = sp_idx;
      ST_MRD2: size_raddr = last_idx;
      ST_MWR1: begin
        size_we    = 1'b1;
        size_waddr = fp_idx;
        size_wdata = merged_sat;
      end
      ST_MWR2: begin
        // The last slot moves into the second pick's slot; when the first pick was the
        // last slot, what moves is the freshly merged size.
        size_we    = 1'b1;
        size_waddr = sp_idx;
        size_wdata = (fp_idx == last_idx) ? merged_q : last_val;
      end
      ST_SN_RD: size_raddr = walk_idx[IDX_W-1:0];
      ST_SN_HWR: hist_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      sizes[size_waddr] <= size_wdata;
    end
    size_rdata <= sizes[size_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[hist_waddr] <= hist_wdata;
    end
    hist_rdata <= hist[hist_raddr];
  end

  gagg_bin_div #(
    .NUM_BINS (NUM_BINS)
  ) u_bin_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == ST_SN_DIV),
    .size   (size_rdata),
    .width  (bin_width),
    .status (div_status),
    .bin    (div_bin)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= INIT_COUNT_RST;
      growth_rate   <= GROWTH_RST;
      snapshot_step <= SNAP_STEP_RST;
      bin_width     <= BIN_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gagg_cfg_idx_t'(cfg_index))
        CFG_INITIAL_COUNT: initial_count <= cfg_data[COUNT_W-1:0];
        CFG_GROWTH_RATE:   growth_rate   <= cfg_data[GROWTH_W-1:0];
        CFG_SNAPSHOT_STEP: snapshot_step <= cfg_data[SNAP_W-1:0];
        CFG_BIN_WIDTH:     bin_width     <= cfg_data[SIZE_BITS-1:0];
      endcase
    end
  end

  // Sequencer and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      live      <= '0;
      step      <= '0;
      walk_idx  <= '0;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + BIN_W'(1);
          if (clr_idx == BIN_W'(NUM_BINS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            walk_idx <= '0;
            unique case (mode)
              MODE_START: begin
                live  <= CNT_W'(start_n);
                step  <= '0;
                state <= (start_n == '0) ? ST_DONE : ST_FILL;
              end
              MODE_MERGE: state <= pick_bad ? ST_DONE : ST_MRD1;
              MODE_READ:  state <= ST_HREAD;
              MODE_NONE:  state <= ST_DONE;
            endcase
          end
        end
        ST_FILL: begin
          walk_idx <= walk_idx + CNT_W'(1);
          if (walk_last) begin
            state <= ST_DONE;
          end
        end
        ST_MRD1: state <= ST_MRD2;
        ST_MRD2: state <= ST_MRD3;
        ST_MRD3: state <= ST_MWR1;
        ST_MWR1: state <= ST_MWR2;
        ST_MWR2: begin
          live  <= live - CNT_W'(1);
          step  <= step_inc;
          state <= snap_hit ? ST_SN_RD : ST_DONE;
        end
        ST_SN_RD:  state <= ST_SN_DIV;
        ST_SN_DIV: state <= ST_SN_WAIT;
        ST_SN_WAIT: begin
          if (div_status.done) begin
            if (div_status.hit) begin
              state <= ST_SN_HWR;
            end else if (walk_last) begin
              state <= ST_DONE;
            end else begin
              walk_idx <= walk_idx + CNT_W'(1);
              state    <= ST_SN_RD;
            end
          end
        end
        ST_SN_HWR: begin
          if (walk_last) begin
            state <= ST_DONE;
          end else begin
            walk_idx <= walk_idx + CNT_W'(1);
            state    <= ST_SN_RD;
          end
        end
        ST_HREAD: state <= ST_DONE;
        ST_DONE: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Merge datapath and result capture.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        fp_idx     <= IDX_W'(req.first_pick);
        sp_idx     <= IDX_W'(req.second_pick);
        last_idx   <= IDX_W'(live - CNT_W'(1));
        merged_q   <= '0;
        res_snap   <= 1'b0;
        res_bad    <= (mode == MODE_MERGE) && pick_bad;
        res_bcount <= '0;
        bsel_ok    <= 32'(req.bin_select) < NUM_BINS;
      end
      ST_MRD1: s1 <= size_rdata;
      ST_MRD2: sum_q <= sum_sat;
      ST_MRD3: begin
        last_val <= size_rdata;
        // floor(sum * alpha / 2^16) is the product with its fraction bits dropped.
        prod     <= PROD_W'(sum_q) * PROD_W'(growth_rate);
      end
      ST_MWR1: merged_q <= merged_sat;
      ST_MWR2: res_snap <= snap_hit;
      ST_HREAD: res_bcount <= bsel_ok ? hist_rdata : '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.merged_size    <= merged_q;
      rsp.particles_left <= COUNT_W'(live);
      rsp.snapshot_done  <= res_snap;
      rsp.bad_pick       <= res_bad;
      rsp.run_finished   <= (live == CNT_W'(1));
      rsp.bin_count      <= res_bcount;
    end
  end

endmodule

// ----- hdl/gagg_checker.sv -----
// Port-level checks of the growth aggregation step and their binding to the top level.
module gagg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_stall,
  input logic                              rsp_valid,
  input logic                              rsp_stall,
  input gagg_pkg::gagg_rsp_t               rsp
);
  import gagg_pkg::*;

  // A stalled result stays offered and unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed or dropped while stalled");

  // Only one item is in work: an accepted item closes the request side for the next cycle.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request side open right after an item was accepted");

  // A rejected merge reports nothing else.
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_pick |->
      rsp.merged_size == '0 && !rsp.snapshot_done && rsp.bin_count == '0)
    else $error("rejected merge carries merge or histogram data");

  // A snapshot comes only with an accepted merge.
  a_snap_merge: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.snapshot_done |-> !rsp.bad_pick && rsp.bin_count == '0)
    else $error("snapshot flagged outside an accepted merge");

  // A bin count belongs to a bin read and never to a merge.
  a_bin_read_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bin_count != '0 |->
      rsp.merged_size == '0 && !rsp.snapshot_done && !rsp.bad_pick)
    else $error("bin count reported alongside a merge");

endmodule

bind growth_aggregation_step gagg_checker u_gagg_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for growth_aggregation_step: random runs against a cycle-free predictor.
`timescale 1ns / 100ps

module testbench;
  import gagg_pkg::*;

  localparam int MAX_P       = MAX_PARTICLES_DEF;
  localparam int NB          = NUM_BINS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  // Length of the long receiver hold-off that fills the block and backs up the sender.
  localparam int HOLD_CYCLES = 400;
  localparam logic [SIZE_BITS-1:0] SIZE_TOP = '1;

  // Clock, reset and the three channels of the block.
  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  gagg_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  gagg_rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Idling controls; the sender reads its own percentage, the receiver reads the other.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  // Each increment of hold_req asks the receiver for one long hold-off.
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  // Statistics of what the stimulus reached, printed at the end.
  int unsigned items_sent = 0;
  int unsigned starts_seen = 0;
  int unsigned merges_seen = 0;
  int unsigned snapshots_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned saturations_seen = 0;

  // Predictor state: its own copy of the registers, the size table and the histogram.
  logic [COUNT_W-1:0]   cfg_count   = INIT_COUNT_RST;
  logic [GROWTH_W-1:0]  cfg_growth  = GROWTH_RST;
  logic [SNAP_W-1:0]    cfg_snap    = SNAP_STEP_RST;
  logic [SIZE_BITS-1:0] cfg_width   = BIN_WIDTH_RST;
  logic [SIZE_BITS-1:0] size_tab [MAX_P];
  logic [BINCNT_W-1:0]  hist_count [NB];
  int unsigned          live_n = 0;
  logic [STEP_W-1:0]    step_n = '0;

  // Results the block still owes, oldest first.
  gagg_rsp_t pending_results [$];

  growth_aggregation_step #(
    .MAX_PARTICLES(MAX_P),
    .NUM_BINS     (NB)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run is cut off if it goes on far past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("growth_aggregation_step verification failed");
      $finish;
    end
  end

  // Receiver. A requested hold-off keeps the result channel stalled until hold_left has
  // counted down; otherwise the stall is drawn at random every cycle.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Reports one field that differs and returns how many it found (zero or one).
  function automatic int unsigned field_mismatch(string field, longint unsigned want,
                                                 longint unsigned got);
    if (want == got) return 0;
    $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    return 1;
  endfunction

  // Result checker. Outputs are sampled at the edge, before anything driven at that edge
  // takes effect, so the handshake seen here is the one the block sees.
  always @(posedge clk) begin
    gagg_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result with no item outstanding: actual %p", $time, rsp);
        mismatches <= mismatches + 1;
      end else begin
        want = pending_results.pop_front();
        mismatches <= mismatches
          + field_mismatch("merged_size", want.merged_size, rsp.merged_size)
          + field_mismatch("particles_left", want.particles_left, rsp.particles_left)
          + field_mismatch("snapshot_done", want.snapshot_done, rsp.snapshot_done)
          + field_mismatch("bad_pick", want.bad_pick, rsp.bad_pick)
          + field_mismatch("run_finished", want.run_finished, rsp.run_finished)
          + field_mismatch("bin_count", want.bin_count, rsp.bin_count);
      end
    end
  end

  // Predictor: applies one accepted item to the local state and returns the result the
  // block must produce for it.
  function automatic gagg_rsp_t aggregate_item(gagg_req_t item);
    gagg_rsp_t res;
    int unsigned last;
    int unsigned i;
    logic [SIZE_BITS:0] sum;
    logic [63:0] product;
    logic [SIZE_BITS:0] total;
    longint unsigned width;
    longint unsigned bin;
    res = '0;
    case (gagg_mode_t'(item.mode))
      MODE_START: begin
        live_n = (cfg_count > MAX_P) ? MAX_P : cfg_count;
        for (i = 0; i < live_n; i++) size_tab[i] = SIZE_ONE;
        step_n = '0;
        starts_seen++;
      end
      MODE_MERGE: begin
        if (live_n < 2 || item.first_pick == item.second_pick ||
            item.first_pick >= live_n || item.second_pick >= live_n) begin
          res.bad_pick = 1'b1;
          rejects_seen++;
        end else begin
          // Sum saturates first, then the growth term floor(sum * alpha / 2^16) is added and the
          // total saturates again.
          sum = {1'b0, size_tab[item.first_pick]} + {1'b0, size_tab[item.second_pick]};
          if (sum[SIZE_BITS]) sum = {1'b0, SIZE_TOP};
          product = 64'(sum[SIZE_BITS-1:0]) * 64'(cfg_growth);
          total = {1'b0, sum[SIZE_BITS-1:0]} + {1'b0, product[63:FRAC_W]};
          if (total[SIZE_BITS]) total = {1'b0, SIZE_TOP};
          if (total[SIZE_BITS-1:0] == SIZE_TOP) saturations_seen++;
          res.merged_size = total[SIZE_BITS-1:0];
          // The last live particle fills the second slot; when the first pick is the
          // last slot, the merged size moves along with it.
          last = live_n - 1;
          size_tab[item.first_pick] = res.merged_size;
          size_tab[item.second_pick] = size_tab[last];
          live_n = last;
          step_n = step_n + 1'b1;
          merges_seen++;
          if (step_n == STEP_W'(cfg_snap)) begin
            // Every live particle lands in bin ceil(size / width) - 1. Empty sizes and
            // sizes past the last bin are not counted; a zero width acts as one.
            width = (cfg_width == '0) ? 1 : cfg_width;
            for (i = 0; i < live_n; i++) begin
              if (size_tab[i] != '0) begin
                bin = size_tab[i] / width + ((size_tab[i] % width) != 0) - 1;
                if (bin < NB && hist_count[bin] != '1) hist_count[bin]++;
              end
            end
            res.snapshot_done = 1'b1;
            snapshots_seen++;
          end
        end
      end
      MODE_READ: res.bin_count = hist_count[item.bin_select];
      default: ;
    endcase
    res.particles_left = COUNT_W'(live_n);
    res.run_finished = (live_n == 1);
    return res;
  endfunction

  function automatic gagg_req_t make_item(gagg_mode_t mode, int unsigned first,
                                          int unsigned second, int unsigned bsel);
    gagg_req_t item;
    item.mode        = mode;
    item.first_pick  = PICK_W'(first);
    item.second_pick = PICK_W'(second);
    item.bin_select  = BSEL_W'(bsel);
    return item;
  endfunction

  // Offers one item, with random idle cycles in front of it, and waits until the block
  // takes it. Valid is left high on return; the next call or drain_results decides it.
  task automatic send_item(gagg_req_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    pending_results = {pending_results, aggregate_item(item)};
    items_sent++;
  endtask

  // Stops offering items and waits until every outstanding result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Writes one register; valid stays high so the next write follows without a gap.
  task automatic write_reg(gagg_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INITIAL_COUNT: cfg_count  = data[COUNT_W-1:0];
      CFG_GROWTH_RATE:   cfg_growth = data[GROWTH_W-1:0];
      CFG_SNAPSHOT_STEP: cfg_snap   = data[SNAP_W-1:0];
      CFG_BIN_WIDTH:     cfg_width  = data[SIZE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Rewrites the whole register set. Only called with the block idle.
  task automatic write_regs(logic [COUNT_W-1:0] count, logic [GROWTH_W-1:0] growth,
                            logic [SNAP_W-1:0] snap, logic [SIZE_BITS-1:0] width);
    write_reg(CFG_INITIAL_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_GROWTH_RATE, CFG_DATA_W'(growth));
    write_reg(CFG_SNAPSHOT_STEP, CFG_DATA_W'(snap));
    write_reg(CFG_BIN_WIDTH, CFG_DATA_W'(width));
    cfg_valid <= 1'b0;
  endtask

  // Right after reset: no particles, so merges are rejected and the first and last bins read zero.
  task automatic test_idle_after_reset();
    send_item(make_item(MODE_MERGE, 0, 1, 0));
    send_item(make_item(MODE_READ, 0, 0, 0));
    send_item(make_item(MODE_READ, 1023, 1023, NB - 1));
    send_item(make_item(MODE_NONE, 0, 0, 0));
  endtask

  // Run starts with no particle, one particle and more than the table holds, plus the
  // rejected merge cases and a merge whose first pick is the last slot.
  task automatic test_start_limits();
    drain_results();
    write_regs(0, 0, 1, BIN_WIDTH_RST);
    send_item(make_item(MODE_START, 0, 0, 0));
    send_item(make_item(MODE_MERGE, 0, 1, 0));
    drain_results();
    write_regs(1, 0, 1, BIN_WIDTH_RST);
    send_item(make_item(MODE_START, 0, 0, 0));
    send_item(make_item(MODE_MERGE, 0, 0, 0));
    drain_results();
    // A snapshot step of zero is never reached, which keeps the full table cheap.
    write_regs(2047, 65535, 0, BIN_WIDTH_RST);
    send_item(make_item(MODE_START, 0, 0, 0));
    send_item(make_item(MODE_MERGE, 1023, 0, 0));
    send_item(make_item(MODE_MERGE, 5, 5, 0));
    send_item(make_item(MODE_MERGE, 1023, 0, 0));
    send_item(make_item(MODE_NONE, 1023, 1023, NB - 1));
  endtask

  // Five unit particles, snapshot on the second merge: sizes 2, 2 and 1 fill bins 1 and 0.
  task automatic test_snapshot();
    drain_results();
    write_regs(5, 0, 2, BIN_WIDTH_RST);
    send_item(make_item(MODE_START, 0, 0, 0));
    send_item(make_item(MODE_MERGE, 0, 1, 0));
    send_item(make_item(MODE_MERGE, 1, 2, 0));
    send_item(make_item(MODE_READ, 0, 0, 0));
    send_item(make_item(MODE_READ, 0, 0, 1));
  endtask

  // A zero bin width pushes every size past the last bin; the widest width puts all in
  // bin zero.
  task automatic test_bin_width_extremes();
    drain_results();
    write_regs(4, 65535, 1, '0);
    send_item(make_item(MODE_START, 0, 0, 0));
    send_item(make_item(MODE_MERGE, 3, 1, 0));
    drain_results();
    write_regs(3, 0, 1, SIZE_TOP);
    send_item(make_item(MODE_START, 0, 0, 0));
    send_item(make_item(MODE_MERGE, 0, 2, 0));
    send_item(make_item(MODE_READ, 0, 0, 0));
  endtask

  // Noise item: merges with equal or random picks, bin reads, the unused mode and the
  // occasional restart, with every other field random.
  task automatic send_noise();
    int unsigned roll;
    int unsigned first;
    roll = $urandom_range(0, 99);
    first = $urandom_range(0, 1023);
    if (roll < 20)
      send_item(make_item(MODE_MERGE, first, first, $urandom_range(0, 63)));
    else if (roll < 40)
      send_item(make_item(MODE_MERGE, first, $urandom_range(0, 1023), $urandom_range(0, 63)));
    else if (roll < 75)
      send_item(make_item(MODE_READ, first, $urandom_range(0, 1023), $urandom_range(0, 63)));
    else if (roll < 92)
      send_item(make_item(MODE_NONE, first, $urandom_range(0, 1023), $urandom_range(0, 63)));
    else
      send_item(make_item(MODE_START, first, $urandom_range(0, 1023), $urandom_range(0, 63)));
  endtask

  // One run with random settings: start, a stream of merges with some noise mixed in,
  // then a few bin reads. Chain runs keep merging into slot zero with the largest or a
  // near-largest growth so that the sizes climb to saturation.
  task automatic random_run();
    int unsigned roll;
    int unsigned count;
    int unsigned n;
    int unsigned merges;
    int unsigned steps;
    int unsigned first;
    int unsigned second;
    bit chain;
    logic [GROWTH_W-1:0] growth;
    logic [SNAP_W-1:0] snap;
    logic [SIZE_BITS-1:0] width;

    roll = $urandom_range(0, 99);
    chain = (roll < 12);
    if (chain) count = $urandom_range(34, 48);
    else if (roll < 18) count = $urandom_range(1024, 2047);
    else if (roll < 23) count = $urandom_range(0, 1);
    else if (roll < 32) count = $urandom_range(60, 300);
    else count = $urandom_range(2, 40);
    n = (count > MAX_P) ? MAX_P : count;
    merges = (n < 2) ? 0 : n - 1;
    if (!chain && n > 40) merges = $urandom_range(15, 60);

    roll = $urandom_range(0, 99);
    if (chain) growth = (roll < 50) ? 16'hFFFF : GROWTH_W'($urandom_range(60000, 65535));
    else if (roll < 25) growth = '0;
    else if (roll < 40) growth = 16'hFFFF;
    else growth = GROWTH_W'($urandom_range(0, 65535));

    roll = $urandom_range(0, 99);
    if (roll < 10) snap = SNAP_W'($urandom_range(0, 1023));
    else if (roll < 15) snap = '1;
    else if (roll < 20) snap = '0;
    else snap = SNAP_W'($urandom_range(1, (merges > 0) ? merges : 1));

    roll = $urandom_range(0, 99);
    if (roll < 8) width = 48'd1;
    else if (roll < 16) width = SIZE_TOP;
    else if (roll < 22) width = '0;
    else if (roll < 35) width = SIZE_BITS'({$urandom, $urandom});
    else width = (SIZE_BITS'(1) << (FRAC_W + $urandom_range(0, 6))) + $urandom_range(0, 3);

    drain_results();
    write_regs(COUNT_W'(count), growth, snap, width);
    send_item(make_item(MODE_START, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 63)));
    steps = merges + $urandom_range(1, 4);
    repeat (steps) begin
      if (live_n >= 2 && $urandom_range(0, 99) < 86) begin
        if (chain) begin
          first = 0;
          second = $urandom_range(1, live_n - 1);
        end else begin
          first = ($urandom_range(0, 9) == 0) ? live_n - 1 : $urandom_range(0, live_n - 1);
          second = $urandom_range(0, live_n - 2);
          if (second >= first) second++;
        end
        send_item(make_item(MODE_MERGE, first, second, $urandom_range(0, 63)));
      end else begin
        send_noise();
      end
    end
    repeat ($urandom_range(2, 4))
      send_item(make_item(MODE_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 63)));
  endtask

  // One idling phase of random runs, ending once the phase has sent its share of items.
  task automatic test_traffic_phase(int unsigned send_pct, int unsigned recv_pct,
                                    int unsigned quota);
    int unsigned goal;
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
    goal = items_sent + quota;
    while (items_sent < goal) random_run();
  endtask

  // The receiver holds off for a long stretch while merges keep coming, so the block
  // fills its output register and then stalls its input.
  task automatic test_backpressure();
    int unsigned first;
    int unsigned second;
    drain_results();
    write_regs(300, 1234, 0, BIN_WIDTH_RST);
    send_item(make_item(MODE_START, 0, 0, 0));
    hold_req <= hold_req + 1;
    repeat (30) begin
      first = $urandom_range(0, live_n - 1);
      second = $urandom_range(0, live_n - 2);
      if (second >= first) second++;
      send_item(make_item(MODE_MERGE, first, second, $urandom_range(0, 63)));
    end
  endtask

  // Test sequence. Reset is applied once; the histogram clear that follows it is covered
  // by the handshake, since no item is taken until it is over.
  initial begin
    foreach (hist_count[b]) hist_count[b] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_idle_after_reset();
    test_start_limits();
    test_snapshot();
    test_bin_width_extremes();

    test_traffic_phase(0, 0, 300);
    test_traffic_phase(54, 0, 300);
    test_backpressure();
    test_traffic_phase(0, 54, 300);
    test_traffic_phase(26, 26, 300);

    // Let any stray result show up before the verdict.
    drain_results();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived.", pending_results.size());
      mismatches = mismatches + 1;
    end

    $display("Covered %0d items: %0d run starts, %0d merges (%0d saturated), %0d rejected.",
             items_sent, starts_seen, merges_seen, saturations_seen, rejects_seen);
    $display("Took %0d histogram snapshots across four idling phases and one long hold-off.",
             snapshots_seen);
    if (mismatches == 0) begin
      $display("growth_aggregation_step verification clean");
    end else begin
      $display("growth_aggregation_step verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/gagg_pkg.sv
hdl/gagg_bin_div.sv
hdl/growth_aggregation_step.sv
hdl/gagg_checker.sv
sim/testbench.sv
